// ===== sv/dap_pkg.sv =====
package dap_pkg;

    localparam int CHAR_W     = 8;
    localparam int AMOUNT_W   = 60;
    localparam int FRAC_W     = 27;
    localparam int COUNT_W    = 4;
    localparam int PHASE_W    = 2;

    localparam int FRACTION_DIGITS_DEF  = 8;
    localparam int MAX_WHOLE_DIGITS_DEF = 10;

    localparam logic [PHASE_W-1:0] PH_LEAD  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WHOLE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FRAC  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_TRAIL = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic                term;
        logic                failed;
        logic [AMOUNT_W-1:0] whole_scaled;
        logic [FRAC_W-1:0]   frac;
    } t_scan_req;

    function automatic logic [AMOUNT_W-1:0] pow10(input logic [COUNT_W-1:0] n);
        logic [AMOUNT_W-1:0] p;
        case (n)
            4'd0:    p = 60'd1;
            4'd1:    p = 60'd10;
            4'd2:    p = 60'd100;
            4'd3:    p = 60'd1000;
            4'd4:    p = 60'd10000;
            4'd5:    p = 60'd100000;
            4'd6:    p = 60'd1000000;
            4'd7:    p = 60'd10000000;
            4'd8:    p = 60'd100000000;
            4'd9:    p = 60'd1000000000;
            4'd10:   p = 60'd10000000000;
            default: p = 60'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== sv/decimal_amount_parser_unit.sv =====
// Decimal amount parser: takes one character per cycle (i_valid/o_stall) and,
// on each zero byte, returns one result (o_valid/i_stall) carrying a well-formed
// flag and the amount in units of 10^-FRACTION_DIGITS. Throughput is one byte
// per cycle while not stalled; the result appears in the cycle after its
// terminating byte is taken, out of a single result register. The input stalls
// only while that register holds a result the receiver is stalling; bytes
// before a terminator keep the same rule, so a stalled result stops the stream.
module decimal_amount_parser_unit
    import dap_pkg::*;
#(
    parameter int FRACTION_DIGITS  = FRACTION_DIGITS_DEF,
    parameter int MAX_WHOLE_DIGITS = MAX_WHOLE_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CHAR_W-1:0]   i_char_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_parse_ok,
    output logic [AMOUNT_W-1:0] o_amount_units
);

    t_scan_req req;
    logic      hold;
    logic      take;

    assign o_stall = hold;
    assign take    = i_valid && !hold;

    dap_scanner #(
        .FRACTION_DIGITS  (FRACTION_DIGITS),
        .MAX_WHOLE_DIGITS (MAX_WHOLE_DIGITS)
    ) u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_byte (i_char_byte),
        .o_req       (req)
    );

    dap_result_reg u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_stall        (i_stall),
        .o_hold         (hold),
        .o_valid        (o_valid),
        .o_parse_ok     (o_parse_ok),
        .o_amount_units (o_amount_units)
    );

endmodule

// ===== sv/dap_scanner.sv =====
module dap_scanner
    import dap_pkg::*;
#(
    parameter int FRACTION_DIGITS  = FRACTION_DIGITS_DEF,
    parameter int MAX_WHOLE_DIGITS = MAX_WHOLE_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [CHAR_W-1:0] i_char_byte,
    output t_scan_req         o_req
);

    localparam logic [COUNT_W-1:0] FD_TOP    = COUNT_W'(FRACTION_DIGITS - 1);
    localparam logic [COUNT_W-1:0] FD_LIMIT  = COUNT_W'(FRACTION_DIGITS);
    localparam logic [COUNT_W-1:0] MW_LIMIT  = COUNT_W'(MAX_WHOLE_DIGITS);
    localparam logic [COUNT_W-1:0] MW_SAT    = COUNT_W'(MAX_WHOLE_DIGITS + 1);
    localparam logic [AMOUNT_W-1:0] UNIT_ONE = pow10(COUNT_W'(FRACTION_DIGITS));

    logic [PHASE_W-1:0]  r_phase,  n_phase;
    logic [AMOUNT_W-1:0] r_whole,  n_whole;
    logic [COUNT_W-1:0]  r_wcnt,   n_wcnt;
    logic [FRAC_W-1:0]   r_frac,   n_frac;
    logic [COUNT_W-1:0]  r_fpos,   n_fpos;
    logic                r_failed, n_failed;

    logic [3:0]          digit;
    logic [AMOUNT_W-1:0] whole_add;
    logic [AMOUNT_W-1:0] whole_x10;
    logic [AMOUNT_W-1:0] frac_weight;
    logic [FRAC_W-1:0]   frac_add;

    assign digit       = 4'(i_char_byte - CH_ZERO);
    assign whole_add   = AMOUNT_W'(UNIT_ONE * AMOUNT_W'(digit));
    assign whole_x10   = (r_whole << 3) + (r_whole << 1);
    assign frac_weight = pow10(FD_TOP - r_fpos);
    assign frac_add    = FRAC_W'(frac_weight[FRAC_W-1:0] * FRAC_W'(digit));

    always_comb begin
        n_phase  = r_phase;
        n_whole  = r_whole;
        n_wcnt   = r_wcnt;
        n_frac   = r_frac;
        n_fpos   = r_fpos;
        n_failed = r_failed;
        if (i_take) begin
            if (i_char_byte == CH_NUL) begin
                n_phase  = PH_LEAD;
                n_whole  = '0;
                n_wcnt   = '0;
                n_frac   = '0;
                n_fpos   = '0;
                n_failed = 1'b0;
            end else if (!r_failed) begin
                unique case (r_phase) inside
                    PH_LEAD, PH_WHOLE: begin
                        if (is_digit(i_char_byte)) begin
                            n_phase = PH_WHOLE;
                            if (r_wcnt >= MW_LIMIT) begin
                                n_wcnt   = MW_SAT;
                                n_failed = 1'b1;
                            end else begin
                                n_whole = whole_x10 + whole_add;
                                n_wcnt  = r_wcnt + 1'b1;
                            end
                        end else if (i_char_byte == CH_POINT) begin
                            n_phase = PH_FRAC;
                        end else if (is_blank(i_char_byte)) begin
                            if (r_phase == PH_WHOLE) begin
                                n_phase = PH_TRAIL;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit(i_char_byte)) begin
                            if (r_fpos >= FD_LIMIT) begin
                                n_failed = 1'b1;
                            end else begin
                                n_frac = r_frac + frac_add;
                                n_fpos = r_fpos + 1'b1;
                            end
                        end else if (is_blank(i_char_byte)) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        if (!is_blank(i_char_byte)) begin
                            n_failed = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_whole  <= '0;
            r_wcnt   <= '0;
            r_frac   <= '0;
            r_fpos   <= '0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_whole  <= n_whole;
            r_wcnt   <= n_wcnt;
            r_frac   <= n_frac;
            r_fpos   <= n_fpos;
            r_failed <= n_failed;
        end
    end

    // terminator sees the state built from all earlier bytes
    assign o_req.term         = i_take && (i_char_byte == CH_NUL);
    assign o_req.failed       = r_failed;
    assign o_req.whole_scaled = r_whole;
    assign o_req.frac         = r_frac;

endmodule

// ===== sv/dap_result_reg.sv =====
module dap_result_reg
    import dap_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_scan_req           i_req,
    input  logic                i_stall,
    output logic                o_hold,
    output logic                o_valid,
    output logic                o_parse_ok,
    output logic [AMOUNT_W-1:0] o_amount_units
);

    logic                r_valid;
    logic                r_ok;
    logic [AMOUNT_W-1:0] r_amount;
    logic                load;
    logic [AMOUNT_W-1:0] sum;

    // hold the result while the receiver stalls it
    assign o_hold = r_valid && i_stall;
    assign load   = !o_hold;
    assign sum    = i_req.whole_scaled + AMOUNT_W'(i_req.frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_req.term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_req.term) begin
            r_ok     <= !i_req.failed;
            r_amount <= i_req.failed ? '0 : sum;
        end
    end

    assign o_valid        = r_valid;
    assign o_parse_ok     = r_ok;
    assign o_amount_units = r_amount;

endmodule
